### hw/rtl/chol_pkg.sv
// Package for the Cholesky solver: sizes, payload structs, sequencer states
// and the control struct passed to the arithmetic unit. No dependencies.
`timescale 1ns / 1ps
package chol_pkg;
   localparam int DIM = 6;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W = 3;
   localparam int ADDR_W = 6;
   localparam int MEM_DEPTH = DIM * DIM;

   localparam logic [1:0] CMD_WR_A = 2'd0;
   localparam logic [1:0] CMD_WR_B = 2'd1;
   localparam logic [1:0] CMD_SOLVE = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [2:0]        row;
      logic [2:0]        col;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         index;
      logic signed [31:0] solution;
      logic               ok;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SQRT, OP_DIV
   } op_type;

   typedef struct packed {
      logic               start;
      op_type             op;
      logic signed [63:0] num;
      logic signed [31:0] den;
   } unit_req_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_RDW, ST_MAC, ST_PIVOT, ST_UNIT, ST_WAIT, ST_STORE,
      ST_EMIT, ST_FAIL
   } state_type;

   typedef enum logic [1:0] {
      PH_FACT, PH_FWD, PH_BACK, PH_OUT
   } phase_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -66'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction
endpackage

### hw/rtl/chol_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module chol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 36
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write, then register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### hw/rtl/chol_unit.sv
// Shared iterative unit: 64-bit integer square root or signed division of
// a Q-format numerator, one result bit per cycle. Uses chol_pkg.
`timescale 1ns / 1ps
module chol_unit
   import chol_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  unit_req_type       unit_req,
   output logic               done,
   output logic signed [31:0] result
);
   logic        busy_ff, busy_in;
   op_type      op_ff, op_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;     // remainder
   logic [63:0] src_ff, src_in;     // bits still to bring down
   logic [63:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;

   logic [64:0] trial;
   logic [63:0] rem_sh;
   logic [63:0] mag_num;
   logic [31:0] mag_den;
   logic [64:0] qs;

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      src_in = src_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      mag_num = unit_req.num[63] ? 64'(-unit_req.num) : unit_req.num;
      mag_den = unit_req.den[31] ? 32'(-unit_req.den) : unit_req.den;
      rem_sh = '0;
      trial = '0;
      // load operands
      if (unit_req.start) begin
         busy_in = 1'b1;
         op_in = unit_req.op;
         rem_in = '0;
         quo_in = '0;
         src_in = (unit_req.op == OP_SQRT) ? unit_req.num : mag_num;
         den_in = mag_den;
         neg_in = unit_req.num[63] ^ unit_req.den[31];
         cnt_in = (unit_req.op == OP_SQRT) ? 7'd32 : 7'd64;
      end else if (busy_ff) begin
         // one restoring step
         if (op_ff == OP_SQRT) begin
            rem_sh = {rem_ff[61:0], src_ff[63:62]};
            trial = {1'b0, rem_sh} - {1'b0, quo_ff[61:0], 2'b01};
            src_in = {src_ff[61:0], 2'b00};
         end else begin
            rem_sh = {rem_ff[62:0], src_ff[63]};
            trial = {1'b0, rem_sh} - {33'd0, den_ff};
            src_in = {src_ff[62:0], 1'b0};
         end
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      src_ff <= src_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign and saturate the finished quotient; a root is passed on unsigned
   always_comb begin
      qs = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
      if (op_ff == OP_SQRT) begin
         result = quo_ff[31:0];
      end else begin
         result = sat32({qs[64], qs});
      end
   end
   assign done = done_ff;
endmodule

### hw/rtl/chol_seq.sv
// Sequencer: walks factorisation and both substitutions over the L store
// and vectors, issuing roots and divisions to chol_unit. Uses chol_pkg.
`timescale 1ns / 1ps
module chol_seq
   import chol_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] a_rdata,
   output logic [ADDR_W-1:0]  a_raddr,
   input  logic signed [31:0] l_rdata,
   output logic [ADDR_W-1:0]  l_raddr,
   output logic               l_we,
   output logic [ADDR_W-1:0]  l_waddr,
   output logic signed [31:0] l_wdata,
   input  logic signed [31:0] rhs [DIM],
   output unit_req_type       unit_req,
   input  logic               unit_done,
   input  logic signed [31:0] unit_result,
   output logic               rsp_valid,
   output rsp_type            rsp_data,
   input  logic               rsp_ready,
   output logic               busy
);
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [31:0] opa_ff;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] piv_ff, piv_in;
   logic signed [31:0] w_ff [DIM];
   logic signed [31:0] w_in [DIM];

   logic [IDX_W-1:0] kend;
   logic signed [63:0] diff;
   logic signed [63:0] prod;

   // row-major store address of entry (r, c)
   function automatic logic [ADDR_W-1:0] lidx(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
      return ADDR_W'(r * DIM + c);
   endfunction

   always_comb begin
      unique case (phase_ff)
         PH_FACT: kend = j_ff;
         PH_FWD:  kend = i_ff;
         default: kend = IDX_W'(DIM - 1);
      endcase
      diff = 64'(top_ff) - sum_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff;
      sum_in = sum_ff; top_in = top_ff; piv_in = piv_ff;
      w_in = w_ff;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            state_in = ST_RD;
            phase_in = PH_FACT;
            i_in = '0; j_in = '0;
            k_in = '0; sum_in = '0;
         end
         ST_RD: begin
            state_in = ST_RDW;
         end
         ST_RDW: begin
            // first fetch: operand a; also pivot/top fetch when loop empty
            if (phase_ff == PH_BACK ? (k_ff > kend || k_ff == i_ff) : (k_ff >= kend))
               state_in = ST_PIVOT;
            else
               state_in = ST_MAC;
         end
         ST_MAC: begin
            sum_in = sum_ff + (prod >>> FRAC_BITS);
            k_in = k_ff + 1'b1;
            state_in = ST_RD;
         end
         ST_PIVOT: begin
            state_in = ST_UNIT;
         end
         ST_UNIT: state_in = ST_WAIT;
         ST_WAIT: if (unit_done) state_in = ST_STORE;
         ST_STORE: begin
            sum_in = '0;
            state_in = ST_RD;
            unique case (phase_ff)
               PH_FACT: begin
                  k_in = '0;
                  if (j_ff == i_ff) begin
                     j_in = '0;
                     if (i_ff == IDX_W'(DIM - 1)) begin
                        phase_in = PH_FWD; i_in = '0;
                     end else i_in = i_ff + 1'b1;
                  end else j_in = j_ff + 1'b1;
               end
               PH_FWD: begin
                  w_in[i_ff] = unit_result;
                  k_in = '0;
                  if (i_ff == IDX_W'(DIM - 1)) begin
                     phase_in = PH_BACK;
                     k_in = IDX_W'(DIM - 1);
                  end else i_in = i_ff + 1'b1;
               end
               default: begin
                  w_in[i_ff] = unit_result;
                  if (i_ff == '0) begin
                     phase_in = PH_OUT;
                     state_in = ST_EMIT;
                  end else begin
                     i_in = i_ff - 1'b1;
                     k_in = IDX_W'(DIM - 1);
                  end
               end
            endcase
         end
         ST_EMIT: if (rsp_ready) begin
            if (i_ff == IDX_W'(DIM - 1)) state_in = ST_IDLE;
            else i_in = i_ff + 1'b1;
         end
         ST_FAIL: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // back substitution counts k downward from DIM-1 to i+1
      if (state_ff == ST_MAC && phase_ff == PH_BACK) k_in = k_ff - 1'b1;
      if (state_ff == ST_PIVOT && phase_ff == PH_FACT && j_ff == i_ff &&
          diff <= 64'sd0) state_in = ST_FAIL;
      // take the top term while the operand fetch lands, the pivot in ST_PIVOT
      if (state_ff == ST_RDW)
         top_in = (phase_ff == PH_FACT) ? a_rdata :
                  (phase_ff == PH_FWD) ? rhs[i_ff] : w_ff[i_ff];
      if (state_ff == ST_PIVOT) piv_in = l_rdata;
   end

   // memory addresses, unit requests, busy and response outputs
   always_comb begin
      a_raddr = lidx(i_ff, j_ff);
      unique case (phase_ff)
         PH_FACT: l_raddr = (state_ff == ST_RD) ? lidx(i_ff, k_ff) : lidx(j_ff, k_ff);
         PH_FWD:  l_raddr = (state_ff == ST_RD && k_ff < kend) ? lidx(i_ff, k_ff)
                                                               : lidx(i_ff, i_ff);
         default: l_raddr = (state_ff == ST_RD && k_ff != i_ff) ? lidx(k_ff, i_ff)
                                                                : lidx(i_ff, i_ff);
      endcase
      if (phase_ff == PH_FACT && state_ff != ST_RD) begin
         if (k_ff >= kend) l_raddr = lidx(j_ff, j_ff);
      end
      l_we = (state_ff == ST_STORE) && (phase_ff == PH_FACT);
      l_waddr = lidx(i_ff, j_ff);
      l_wdata = unit_result;
      unit_req.start = (state_ff == ST_UNIT);
      if (phase_ff == PH_FACT && i_ff == j_ff) begin
         unit_req.op = OP_SQRT;
         unit_req.num = {diff[63:32] != 32'd0 || diff[31] ? 64'sh7FFF_FFFF : diff}
                        <<< FRAC_BITS;
      end else begin
         unit_req.op = OP_DIV;
         unit_req.num = 64'(sat32({{2{diff[63]}}, diff})) <<< FRAC_BITS;
      end
      unit_req.den = piv_ff;
      busy = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_FAIL);
      rsp_data.index = (state_ff == ST_FAIL) ? '0 : i_ff;
      rsp_data.solution = (state_ff == ST_FAIL) ? '0 : w_ff[i_ff];
      rsp_data.ok = (state_ff != ST_FAIL);
      rsp_data.last = (state_ff == ST_FAIL) || (i_ff == IDX_W'(DIM - 1));
   end

   // second operand of the product
   always_comb begin
      unique case (phase_ff)
         PH_FACT: prod = opa_ff * l_rdata;
         default: prod = opa_ff * w_ff[k_ff];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_FACT;
         for (int n = 0; n < DIM; n++) w_ff[n] <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         w_ff <= w_in;
      end
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      sum_ff <= sum_in;
      top_ff <= top_in;
      piv_ff <= piv_in;
      // latch the first operand of the product
      if (state_ff == ST_RDW) opa_ff <= l_rdata;
   end
endmodule

### hw/rtl/cholesky_spd_solver_top.sv
// Top level of the Cholesky solver: load stores and hand solves to chol_seq.
// Depends on chol_pkg, chol_ram, chol_unit and chol_seq.
`timescale 1ns / 1ps
// Each load (matrix or right-hand entry) is written on the edge that accepts
// it, so loads can follow back to back. A solve runs a Cholesky
// factorisation, forward and back substitution with one shared
// multiply-accumulate path and one bit-serial root/divide unit, then emits
// six result transfers, or one failure transfer on a bad pivot. The
// block accepts no item while a solve is running. After reset a sweep
// clears the stores before the first item is accepted.
module cholesky_spd_solver_top
   import chol_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic              clr_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic signed [31:0] rhs_ff [DIM];
   logic              busy, start, acc;
   logic              a_we, l_we, l_we_s;
   logic [ADDR_W-1:0] a_waddr, a_raddr, l_waddr, l_waddr_s, l_raddr;
   logic signed [31:0] a_wdata, a_rdata, l_wdata, l_wdata_s, l_rdata;
   unit_req_type      unit_req;
   logic              unit_done;
   logic signed [31:0] unit_result;

   assign req_ready = !busy && !clr_ff;
   assign acc = req_valid && req_ready;
   assign start = acc && req_data.cmd == CMD_SOLVE;

   // clear sweep after reset, then loads
   always_comb begin
      a_we = clr_ff || (acc && req_data.cmd == CMD_WR_A &&
             32'(req_data.row) < DIM && req_data.col <= req_data.row);
      a_waddr = clr_ff ? clr_cnt_ff : ADDR_W'(req_data.row * DIM + req_data.col);
      a_wdata = clr_ff ? '0 : req_data.value;
      l_we = clr_ff || l_we_s;
      l_waddr = clr_ff ? clr_cnt_ff : l_waddr_s;
      l_wdata = clr_ff ? '0 : l_wdata_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         for (int n = 0; n < DIM; n++) rhs_ff[n] <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1)) clr_ff <= 1'b0;
         end
         if (acc && req_data.cmd == CMD_WR_B && 32'(req_data.row) < DIM)
            rhs_ff[req_data.row] <= req_data.value;
      end
   end

   chol_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_a_ram (
      .clock(clock), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
      .raddr(a_raddr), .rdata(a_rdata));

   chol_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_l_ram (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rdata));

   chol_unit u_unit (
      .clock(clock), .reset(reset), .unit_req(unit_req),
      .done(unit_done), .result(unit_result));

   chol_seq u_seq (
      .clock(clock), .reset(reset), .start(start),
      .a_rdata(a_rdata), .a_raddr(a_raddr),
      .l_rdata(l_rdata), .l_raddr(l_raddr),
      .l_we(l_we_s), .l_waddr(l_waddr_s), .l_wdata(l_wdata_s),
      .rhs(rhs_ff), .unit_req(unit_req),
      .unit_done(unit_done), .unit_result(unit_result),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_ready(rsp_ready),
      .busy(busy));
endmodule

### tb/sv/tb.sv
// Self-checking testbench for cholesky_spd_solver_top: loads matrices and
// right-hand sides, solves, and compares every transfer with a local predictor.
// Depends on chol_pkg and the solver RTL.
`timescale 1ns / 1ps
module tb;
   import chol_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   cholesky_spd_solver_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // predictor state
   logic signed [31:0] a_mem [DIM*DIM];
   logic signed [31:0] b_mem [DIM];
   logic signed [31:0] l_mem [DIM*DIM];
   logic signed [31:0] x_vec [DIM];

   rsp_type solution_queue [$];
   int      fail_count;
   int      idle_cycles;
   bit      quiet_tail;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic signed [63:0] fx_mul(input logic signed [31:0] u,
                                                  input logic signed [31:0] v);
      logic signed [63:0] p;
      p = 64'(u) * 64'(v);
      return p >>> FRAC_BITS;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] fx_quot(input logic signed [63:0] num,
                                                  input logic signed [31:0] den);
      logic signed [63:0] n;
      n = 64'(clamp32(num)) <<< FRAC_BITS;
      if (den == 0) return 0;
      return clamp32(n / 64'(den));
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   // factor, substitute twice; 0 on a bad pivot
   function automatic bit factor_and_solve();
      logic signed [63:0] sum, d;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j <= i; j++) begin
            sum = 0;
            for (int k = 0; k < j; k++) sum += fx_mul(l_mem[i*DIM+k], l_mem[j*DIM+k]);
            if (i == j) begin
               d = 64'(a_mem[i*DIM+i]) - sum;
               if (d <= 0) return 0;
               if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
               l_mem[i*DIM+i] = 32'(root64(64'(d) << FRAC_BITS));
            end else begin
               l_mem[i*DIM+j] = fx_quot(64'(a_mem[i*DIM+j]) - sum, l_mem[j*DIM+j]);
            end
         end
      end
      for (int i = 0; i < DIM; i++) begin
         sum = 0;
         for (int j = 0; j < i; j++) sum += fx_mul(l_mem[i*DIM+j], x_vec[j]);
         x_vec[i] = fx_quot(64'(b_mem[i]) - sum, l_mem[i*DIM+i]);
      end
      for (int i = DIM - 1; i >= 0; i--) begin
         sum = 0;
         for (int j = i + 1; j < DIM; j++) sum += fx_mul(l_mem[j*DIM+i], x_vec[j]);
         x_vec[i] = fx_quot(64'(x_vec[i]) - sum, l_mem[i*DIM+i]);
      end
      return 1;
   endfunction

   // update the predictor for one accepted transfer
   task automatic predict_item(input req_type it);
      rsp_type r;
      case (it.cmd)
         CMD_WR_A: if (it.row < DIM && it.col < DIM && it.col <= it.row)
            a_mem[it.row*DIM+it.col] = it.value;
         CMD_WR_B: if (it.row < DIM) b_mem[it.row] = it.value;
         CMD_SOLVE: begin
            if (!factor_and_solve()) begin
               r = '{index: 3'd0, solution: 32'sd0, ok: 1'b0, last: 1'b1};
               solution_queue = {solution_queue, r};
            end else begin
               for (int i = 0; i < DIM; i++) begin
                  r.index = 3'(i);
                  r.solution = x_vec[i];
                  r.ok = 1'b1;
                  r.last = (i == DIM - 1);
                  solution_queue = {solution_queue, r};
               end
            end
         end
         default: ;
      endcase
   endtask

   // valid stays up after the transfer: the next call replaces the payload at
   // this same falling edge, or drops valid for an idle burst
   task automatic send_item(input req_type it);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_item(it);
      @(negedge clock);
   endtask

   task automatic load_random_spd(input bit well_formed);
      req_type it;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j <= i; j++) begin
            it.cmd = CMD_WR_A;
            it.row = 3'(i);
            it.col = 3'(j);
            if (!well_formed) it.value = $urandom;
            else if (i == j) it.value = 32'($urandom_range(4 << 16, 200 << 16));
            else it.value = 32'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
            send_item(it);
         end
         it.cmd = CMD_WR_B;
         it.row = 3'(i);
         it.col = 3'($urandom);
         it.value = ($urandom_range(0, 3) == 0) ? $urandom
                    : 32'(int'($urandom_range(0, 64 << 16)) - (32 << 16));
         send_item(it);
      end
   endtask

   // receiver: random stall bursts, checks each transfer
   initial begin
      rsp_type want;
      int stall;
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(1, 8);
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if (rsp_valid) begin
            if (solution_queue.size() == 0) begin
               $error("unexpected result transfer: %p", rsp_data);
               fail_count++;
            end else begin
               want = solution_queue.pop_front();
               if (rsp_data.index !== want.index) begin
                  $error("index: expected %0d, got %0d", want.index, rsp_data.index);
                  fail_count++;
               end
               if (rsp_data.solution !== want.solution) begin
                  $error("solution: expected %0d, got %0d", want.solution,
                         rsp_data.solution);
                  fail_count++;
               end
               if (rsp_data.ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_data.ok);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         @(negedge clock);
      end
   end

   // watchdog: count cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // directed rows: cmd, row, col, value
   req_type directed_rows [] = '{
      '{CMD_SOLVE, 3'd0, 3'd0, 32'sd0},               // all-zero stores: failure
      '{CMD_WR_A, 3'd0, 3'd0, 32'sh7FFF_FFFF},
      '{CMD_WR_A, 3'd1, 3'd1, 32'sh0001_0000},
      '{CMD_WR_A, 3'd2, 3'd2, 32'sh0001_0000},
      '{CMD_WR_A, 3'd3, 3'd3, 32'sh0001_0000},
      '{CMD_WR_A, 3'd4, 3'd4, 32'sh0001_0000},
      '{CMD_WR_A, 3'd5, 3'd5, 32'sh0004_0000},
      '{CMD_WR_A, 3'd1, 3'd0, 32'sh8000_0000},
      '{CMD_WR_A, 3'd2, 3'd5, 32'sh1234_5678},        // upper triangle: ignored
      '{CMD_WR_A, 3'd7, 3'd6, 32'sh7FFF_FFFF},        // index beyond size: ignored
      '{CMD_WR_B, 3'd0, 3'd7, 32'sh7FFF_FFFF},
      '{CMD_WR_B, 3'd5, 3'd0, 32'sh8000_0000},
      '{CMD_WR_B, 3'd6, 3'd0, 32'sh5555_5555},        // index beyond size: ignored
      '{2'd3, 3'd7, 3'd7, 32'shFFFF_FFFF},            // unused command: ignored
      '{CMD_SOLVE, 3'd0, 3'd0, 32'sd0},
      '{CMD_WR_A, 3'd1, 3'd0, 32'sd0},
      '{CMD_WR_A, 3'd3, 3'd3, 32'sh8000_0000},        // negative pivot
      '{CMD_SOLVE, 3'd5, 3'd2, 32'shAAAA_AAAA},
      '{CMD_WR_A, 3'd3, 3'd3, 32'sh0000_0001},
      '{CMD_SOLVE, 3'd0, 3'd0, 32'sd0}
   };
   // only the failure results are typed in; -1 means use the predictor
   int directed_fail [] = '{1, -1,-1,-1,-1,-1,-1,-1,-1,-1,-1,-1,-1,-1, -1, -1,-1, 1,
                            -1, -1};

   initial begin
      req_type it;
      fail_count = 0;
      quiet_tail = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      for (int i = 0; i < DIM*DIM; i++) begin
         a_mem[i] = 0;
         l_mem[i] = 0;
      end
      for (int i = 0; i < DIM; i++) begin
         b_mem[i] = 0;
         x_vec[i] = 0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[n]) begin
         send_item(directed_rows[n]);
         if (directed_fail[n] == 1 && (solution_queue.size() == 0 ||
             solution_queue[$].ok !== 1'b0 || solution_queue[$].last !== 1'b1)) begin
            $error("directed row %0d: failure result expected", n);
            fail_count++;
         end
      end

      // random part: mostly well-formed systems, some noise
      for (int s = 0; s < 9; s++) begin
         if (s == 4) begin
            // hold the sender until every result has drained
            req_valid <= 1'b0;
            do @(negedge clock); while (solution_queue.size() != 0);
         end
         if (s == 7) quiet_tail = 1;
         load_random_spd(s % 4 != 3);
         repeat ($urandom_range(0, 3)) begin
            it.cmd = 2'($urandom);
            it.row = 3'($urandom);
            it.col = 3'($urandom);
            it.value = $urandom;
            if (it.cmd == CMD_SOLVE) it.cmd = CMD_WR_A;
            send_item(it);
         end
         it = '{CMD_SOLVE, 3'($urandom), 3'($urandom), $urandom};
         send_item(it);
      end
      req_valid <= 1'b0;

      while (solution_queue.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### sim.f
hw/rtl/chol_pkg.sv
hw/rtl/chol_ram.sv
hw/rtl/chol_unit.sv
hw/rtl/chol_seq.sv
hw/rtl/cholesky_spd_solver_top.sv
tb/sv/tb.sv
